// File: rtl/plkc_pkg.sv
// plkc_pkg: payload, storage and control types plus status codes for the pinned lru key cache
// no dependencies; used by plkc_ctrl, plkc_dp and pinned_lru_key_cache_top
package plkc_pkg;

    localparam int STAMP_W = 32;

    localparam logic [2:0] STAT_HIT       = 3'd0;
    localparam logic [2:0] STAT_FILL      = 3'd1;
    localparam logic [2:0] STAT_EVICT     = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_REL       = 3'd4;
    localparam logic [2:0] STAT_REL_EMPTY = 3'd5;

    localparam logic CMD_LOOKUP  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic        command;
        logic [15:0] style;
        logic [7:0]  font_size;
        logic [4:0]  release_slot;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [15:0] evicted_style;
        logic [7:0]  evicted_size;
        logic [7:0]  ref_count;
    } out_t;

    typedef struct packed {
        logic [15:0]        style;
        logic [7:0]         size;
        logic [STAMP_W-1:0] stamp;
        logic [7:0]         refs;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REL_RD,
        S_COMMIT,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic rel_read;
        logic commit;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_release;
        logic hit_now;
        logic scan_end;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/plkc_ctrl.sv
// plkc_ctrl: sequencing state machine for lookup, release and result hand-off
// depends on plkc_pkg
module plkc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  plkc_pkg::dp_stat_t  stat,
    output plkc_pkg::ctrl_cmd_t cmd
);

    plkc_pkg::state_t state_reg;
    plkc_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= plkc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            plkc_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = stat.in_release ? plkc_pkg::S_REL_RD : plkc_pkg::S_SCAN;
                end
            end
            plkc_pkg::S_SCAN: begin
                if (stat.hit_now || stat.scan_end) begin
                    state_next = plkc_pkg::S_COMMIT;
                end
            end
            plkc_pkg::S_REL_RD: begin
                state_next = plkc_pkg::S_COMMIT;
            end
            plkc_pkg::S_COMMIT: begin
                state_next = plkc_pkg::S_FINISH;
            end
            plkc_pkg::S_FINISH: begin
                if (stat.out_free) begin
                    state_next = plkc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = plkc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            plkc_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            plkc_pkg::S_SCAN: begin
                cmd.scan = 1'b1;
            end
            plkc_pkg::S_REL_RD: begin
                cmd.rel_read = 1'b1;
            end
            plkc_pkg::S_COMMIT: begin
                cmd.commit = 1'b1;
            end
            plkc_pkg::S_FINISH: begin
                cmd.emit = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/plkc_dp.sv
// plkc_dp: slot memory, valid bits, scan accumulators, update logic and output register
// depends on plkc_pkg; driven by plkc_ctrl
module plkc_dp #(
    parameter int ENTRIES = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  plkc_pkg::in_t       s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output plkc_pkg::out_t      m_data,
    input  plkc_pkg::ctrl_cmd_t cmd,
    output plkc_pkg::dp_stat_t  stat
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // slot storage, one read and one write port
    plkc_pkg::entry_t entry_mem [ENTRIES];

    logic [ENTRIES-1:0] valid_reg;
    logic [plkc_pkg::STAMP_W-1:0] use_clock_reg;

    // accepted transaction
    logic        cmd_reg;
    logic [15:0] key_style_reg;
    logic [7:0]  key_size_reg;
    logic [4:0]  rel_reg;

    // read pipeline
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    plkc_pkg::entry_t rd_data_reg;
    logic             rd_vld_reg;

    // scan results
    logic                         hit_found_reg;
    logic [IDX_W-1:0]             hit_idx_reg;
    logic [7:0]                   hit_refs_reg;
    logic                         have_empty_reg;
    logic [IDX_W-1:0]             empty_idx_reg;
    logic                         have_old_reg;
    logic [IDX_W-1:0]             old_idx_reg;
    logic [plkc_pkg::STAMP_W-1:0] old_stamp_reg;
    logic [15:0]                  old_style_reg;
    logic [7:0]                   old_size_reg;

    plkc_pkg::out_t res_reg;
    plkc_pkg::out_t res_next;
    plkc_pkg::out_t m_data_reg;
    logic           m_valid_reg;

    logic             scan_issue;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] rel_idx;
    logic             rel_in_range;
    logic             key_match;
    logic             older;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    plkc_pkg::entry_t wr_data;
    logic             set_valid;
    logic [7:0]       rel_refs_next;

    assign rel_idx      = IDX_W'(rel_reg);
    assign rel_in_range = 32'(rel_reg) < ENTRIES;
    assign scan_issue   = cmd.scan && (scan_cnt_reg < CNT_W'(ENTRIES));
    assign rd_en        = scan_issue || cmd.rel_read;
    assign rd_addr      = cmd.rel_read ? rel_idx : scan_cnt_reg[IDX_W-1:0];

    assign key_match = rd_vld_reg && (rd_data_reg.style == key_style_reg)
                       && (rd_data_reg.size == key_size_reg);
    assign older     = !have_old_reg || (rd_data_reg.stamp < old_stamp_reg);

    assign stat.in_release = (s_data.command == plkc_pkg::CMD_RELEASE);
    assign stat.hit_now    = cmp_vld_reg && key_match;
    assign stat.scan_end   = cmp_vld_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign stat.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
        end
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    assign rel_refs_next = (rd_data_reg.refs == 8'd0) ? 8'd0 : rd_data_reg.refs - 8'd1;

    // update decision for the commit cycle
    always_comb begin
        wr_en     = 1'b0;
        set_valid = 1'b0;
        wr_addr   = hit_idx_reg;
        wr_data   = '{style: key_style_reg, size: key_size_reg,
                      stamp: use_clock_reg, refs: 8'd1};
        res_next  = '0;
        if (cmd_reg == plkc_pkg::CMD_RELEASE) begin
            wr_addr      = rel_idx;
            wr_data      = rd_data_reg;
            wr_data.refs = rel_refs_next;
            res_next.slot = rel_reg;
            if (rel_in_range && rd_vld_reg) begin
                wr_en              = cmd.commit;
                res_next.status    = plkc_pkg::STAT_REL;
                res_next.ref_count = rel_refs_next;
            end else begin
                res_next.status = plkc_pkg::STAT_REL_EMPTY;
            end
        end else if (hit_found_reg) begin
            wr_en        = cmd.commit;
            wr_addr      = hit_idx_reg;
            wr_data.refs = (hit_refs_reg == 8'hFF) ? 8'hFF : hit_refs_reg + 8'd1;
            res_next.status    = plkc_pkg::STAT_HIT;
            res_next.slot      = 5'(hit_idx_reg);
            res_next.ref_count = wr_data.refs;
        end else if (have_empty_reg) begin
            wr_en     = cmd.commit;
            set_valid = cmd.commit;
            wr_addr   = empty_idx_reg;
            res_next.status    = plkc_pkg::STAT_FILL;
            res_next.slot      = 5'(empty_idx_reg);
            res_next.ref_count = 8'd1;
        end else if (have_old_reg) begin
            wr_en   = cmd.commit;
            wr_addr = old_idx_reg;
            res_next.status        = plkc_pkg::STAT_EVICT;
            res_next.slot          = 5'(old_idx_reg);
            res_next.evicted_style = old_style_reg;
            res_next.evicted_size  = old_size_reg;
            res_next.ref_count     = 8'd1;
        end else begin
            res_next.status = plkc_pkg::STAT_FULL;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            use_clock_reg <= '0;
            scan_cnt_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cmp_vld_reg <= scan_issue;
            if (cmd.load) begin
                scan_cnt_reg <= '0;
            end else if (scan_issue) begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
            if (set_valid) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (wr_en && (cmd_reg == plkc_pkg::CMD_LOOKUP)) begin
                use_clock_reg <= use_clock_reg + 32'd1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and scan accumulators
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        if (cmd.load) begin
            cmd_reg        <= s_data.command;
            key_style_reg  <= s_data.style;
            key_size_reg   <= s_data.font_size;
            rel_reg        <= s_data.release_slot;
            hit_found_reg  <= 1'b0;
            have_empty_reg <= 1'b0;
            have_old_reg   <= 1'b0;
        end else if (cmd.scan && cmp_vld_reg) begin
            if (key_match) begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= cmp_idx_reg;
                hit_refs_reg  <= rd_data_reg.refs;
            end else if (!rd_vld_reg) begin
                have_empty_reg <= 1'b1;
                empty_idx_reg  <= cmp_idx_reg;
            end else if ((rd_data_reg.refs == 8'd0) && older) begin
                have_old_reg  <= 1'b1;
                old_idx_reg   <= cmp_idx_reg;
                old_stamp_reg <= rd_data_reg.stamp;
                old_style_reg <= rd_data_reg.style;
                old_size_reg  <= rd_data_reg.size;
            end
        end
        if (cmd.commit) begin
            res_reg <= res_next;
        end
        if (cmd.emit) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/pinned_lru_key_cache_top.sv
// pinned_lru_key_cache_top: fully associative lru key cache with reference pinning
// depends on plkc_pkg, plkc_ctrl and plkc_dp
//
// channel  dir  ports                       payload
// -------  ---  --------------------------  ----------------------------------------------
// s_       in   s_valid, s_ready, s_data    command, style, font_size, release_slot
// m_       out  m_valid, m_ready, m_data    status, slot, evicted_style, evicted_size, ref_count
//
// a lookup walks the slot memory one entry per cycle, through every slot on a miss;
// a hit at slot i ends the walk early; a release reads its slot once and writes it back
// reset clears valid bits and the use clock at once; slot contents need no clearing
// a result waits in the output register while m_ready is low; a new transaction is
// taken meanwhile, and its own result holds until the register frees up
module pinned_lru_key_cache_top #(
    parameter int ENTRIES = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  plkc_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output plkc_pkg::out_t m_data
);

    plkc_pkg::ctrl_cmd_t cmd;
    plkc_pkg::dp_stat_t  stat;

    // sequencing
    plkc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // storage, scan and result
    plkc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

    // one transaction at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a transaction while the previous one was in flight");

    // a full cache reports slot zero with no references
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == plkc_pkg::STAT_FULL)
        |-> (m_data.slot == 5'd0) && (m_data.ref_count == 8'd0))
        else $error("full result carries slot or reference data");

    // evicted key fields only with an eviction
    a_evict_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != plkc_pkg::STAT_EVICT)
        |-> (m_data.evicted_style == 16'd0) && (m_data.evicted_size == 8'd0))
        else $error("evicted key reported without an eviction");

    // a lookup that places or finds its key always holds a reference
    a_lookup_refs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_data.status == plkc_pkg::STAT_HIT)
                 || (m_data.status == plkc_pkg::STAT_FILL)
                 || (m_data.status == plkc_pkg::STAT_EVICT))
        |-> (m_data.ref_count != 8'd0))
        else $error("lookup result with zero references");

    // results only appear after the commit and finish steps of a transaction
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.emit))
        else $error("result raised without a finish step");

endmodule

// File: sim/testbench.sv
// testbench for pinned_lru_key_cache_top: a shadow copy of the slot table predicts every reply
// depends on plkc_pkg and the rtl of pinned_lru_key_cache_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plkc_pkg::*;

    localparam int ENTRIES      = 32;
    localparam int RANDOM_ITEMS = 800;
    localparam int MAX_IDLE     = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int POOL_KEYS    = 40;
    // about 1100 transactions at worst, each a full scan plus two idle gaps, several times over
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 10;

    // shadow of the slot table plus the queue of replies it predicts
    class lru_cache_shadow;
        bit        slot_used  [ENTRIES];
        bit [15:0] slot_style [ENTRIES];
        bit [7:0]  slot_size  [ENTRIES];
        bit [31:0] slot_stamp [ENTRIES];
        bit [7:0]  slot_refs  [ENTRIES];
        bit [31:0] use_count;
        out_t      expected_replies [$];
        int        mismatches;

        // new timestamp and one more reference, saturating
        function void refresh(int idx);
            slot_stamp[idx] = use_count;
            use_count++;
            if (slot_refs[idx] != 8'hFF) begin
                slot_refs[idx]++;
            end
        endfunction

        // accepted request transaction: update the shadow and queue its reply
        function void note_request(in_t req);
            out_t rep;
            int   empty_idx;
            int   oldest_idx;
            bit   found;
            rep        = '0;
            empty_idx  = -1;
            oldest_idx = -1;
            found      = 1'b0;
            if (req.command == CMD_RELEASE) begin
                rep.slot = req.release_slot;
                if (!slot_used[req.release_slot]) begin
                    rep.status = STAT_REL_EMPTY;
                end else begin
                    if (slot_refs[req.release_slot] != 0) begin
                        slot_refs[req.release_slot]--;
                    end
                    rep.status    = STAT_REL;
                    rep.ref_count = slot_refs[req.release_slot];
                end
                expected_replies.push_back(rep);
                return;
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_used[i]) begin
                    if (slot_style[i] == req.style && slot_size[i] == req.font_size) begin
                        refresh(i);
                        rep.status    = STAT_HIT;
                        rep.slot      = 5'(i);
                        rep.ref_count = slot_refs[i];
                        found         = 1'b1;
                        break;
                    end
                    if (slot_refs[i] == 0 &&
                        (oldest_idx < 0 || slot_stamp[i] < slot_stamp[oldest_idx])) begin
                        oldest_idx = i;
                    end
                end else begin
                    empty_idx = i;
                end
            end
            if (!found) begin
                if (empty_idx >= 0) begin
                    slot_used[empty_idx]  = 1'b1;
                    slot_style[empty_idx] = req.style;
                    slot_size[empty_idx]  = req.font_size;
                    slot_refs[empty_idx]  = '0;
                    refresh(empty_idx);
                    rep.status    = STAT_FILL;
                    rep.slot      = 5'(empty_idx);
                    rep.ref_count = slot_refs[empty_idx];
                end else if (oldest_idx < 0) begin
                    rep.status = STAT_FULL;
                end else begin
                    rep.evicted_style      = slot_style[oldest_idx];
                    rep.evicted_size       = slot_size[oldest_idx];
                    slot_style[oldest_idx] = req.style;
                    slot_size[oldest_idx]  = req.font_size;
                    slot_refs[oldest_idx]  = '0;
                    refresh(oldest_idx);
                    rep.status    = STAT_EVICT;
                    rep.slot      = 5'(oldest_idx);
                    rep.ref_count = slot_refs[oldest_idx];
                end
            end
            expected_replies.push_back(rep);
        endfunction

        // accepted reply transaction: compare with the oldest prediction
        function void check_reply(out_t got);
            out_t want;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("reply with no request pending: status %0d slot %0d ev %h/%h refs %0d",
                             got.status, got.slot, got.evicted_style, got.evicted_size,
                             got.ref_count);
                end
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.evicted_style !== want.evicted_style ||
                got.evicted_size !== want.evicted_size || got.ref_count !== want.ref_count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("reply mismatch: expected status %0d slot %0d ev %h/%h refs %0d",
                             want.status, want.slot, want.evicted_style, want.evicted_size,
                             want.ref_count);
                    $display("                got      status %0d slot %0d ev %h/%h refs %0d",
                             got.status, got.slot, got.evicted_style, got.evicted_size,
                             got.ref_count);
                end
            end
        endfunction

        // a slot that still holds references, so that releases mostly do real work
        function bit [4:0] pick_held_slot();
            int held [$];
            foreach (slot_used[i]) begin
                if (slot_used[i] && slot_refs[i] != 0) begin
                    held.push_back(i);
                end
            end
            if (held.size() == 0) begin
                return 5'($urandom_range(0, ENTRIES - 1));
            end
            return 5'(held[$urandom_range(0, held.size() - 1)]);
        endfunction
    endclass

    // dut signals, all inputs known from time zero
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    // receiver ready is its own per-transaction wish, masked by the long hold-off
    logic rx_want = 1'b0;
    logic rx_hold = 1'b0;
    assign m_ready = rx_want & ~rx_hold;

    lru_cache_shadow model = new();

    bit        quiet_sender;   // no gaps between request transactions
    bit        offering;       // s_valid left high after the last acceptance
    int        idle_owed;      // gap still to wait before the next request
    int        requests_sent;
    bit        hold_go;
    bit [15:0] pool_style [POOL_KEYS];
    bit [7:0]  pool_size  [POOL_KEYS];

    pinned_lru_key_cache_top #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic in_t lookup_req(bit [15:0] st, bit [7:0] sz);
        in_t req;
        req.command      = CMD_LOOKUP;
        req.style        = st;
        req.font_size    = sz;
        req.release_slot = 5'($urandom);   // ignored by a lookup, still toggled
        return req;
    endfunction

    function automatic in_t release_req(bit [4:0] sl);
        in_t req;
        req.command      = CMD_RELEASE;
        req.style        = 16'($urandom);  // ignored by a release
        req.font_size    = 8'($urandom);
        req.release_slot = sl;
        return req;
    endfunction

    // offer one request transaction and return at the edge that accepts it;
    // with no gap drawn, s_valid stays high for the next call in the same step
    task automatic send_request(input in_t req);
        if (idle_owed > 0) begin
            repeat (idle_owed) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        model.note_request(req);
        requests_sent++;
        idle_owed = quiet_sender ? 0 : $urandom_range(0, MAX_IDLE);
        if (idle_owed > 0) begin
            s_valid <= 1'b0;
        end
        offering = (idle_owed == 0);
    endtask

    // drop valid if still up, then wait until every predicted reply has come back
    task automatic wait_replies_drained();
        if (offering) begin
            s_valid <= 1'b0;
        end
        offering = 1'b0;
        while (model.expected_replies.size() != 0) @(posedge aclk);
    endtask

    // mixed traffic: pool keys give hits and evictions, release share set per burst
    task automatic run_mix(input int len);
        int rel_pct;
        int k;
        case ($urandom_range(0, 2))
            0: begin
                rel_pct = 10;
            end
            1: begin
                rel_pct = 40;
            end
            default: begin
                rel_pct = 60;
            end
        endcase
        repeat (len) begin
            if ($urandom_range(0, 99) < rel_pct) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_request(release_req(5'($urandom_range(0, ENTRIES - 1))));
                end else begin
                    send_request(release_req(model.pick_held_slot()));
                end
            end else if ($urandom_range(0, 4) == 0) begin
                send_request(lookup_req(16'($urandom), 8'($urandom)));
            end else begin
                k = $urandom_range(0, POOL_KEYS - 1);
                send_request(lookup_req(pool_style[k], pool_size[k]));
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        int  random_goal;
        int  sat_slot;
        bit  did_saturate;
        bit  did_hold;
        int  kind;
        foreach (pool_style[i]) begin
            pool_style[i] = 16'($urandom);
            pool_size[i]  = 8'($urandom);
        end
        pool_style[0] = 16'h0000;
        pool_size[0]  = 8'h00;
        pool_style[1] = 16'hFFFF;
        pool_size[1]  = 8'hFF;

        // reset held low from time zero, then released
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: release on empty slots at both ends of the index range
        send_request(release_req(5'd31));
        send_request(release_req(5'd0));
        // fills land in the highest free slot, key extremes and mixed halves
        send_request(lookup_req(16'h0000, 8'h00));
        send_request(lookup_req(16'hFFFF, 8'hFF));
        send_request(lookup_req(16'hFFFF, 8'h00));
        send_request(lookup_req(16'h0000, 8'hFF));
        // hit adds a reference
        send_request(lookup_req(16'h0000, 8'h00));
        // releases down to zero, one more on an unreferenced slot, then one on an empty slot
        send_request(release_req(5'd31));
        send_request(release_req(5'd31));
        send_request(release_req(5'd31));
        send_request(release_req(5'd30));
        send_request(release_req(5'd29));
        send_request(release_req(5'd1));
        // hit on a slot with no references left
        send_request(lookup_req(16'h0000, 8'h00));
        wait_replies_drained();

        // random part, built from bursts of different shapes
        random_goal  = requests_sent + RANDOM_ITEMS;
        did_saturate = 1'b0;
        did_hold     = 1'b0;
        while (requests_sent < random_goal) begin
            quiet_sender = ($urandom_range(0, 3) == 0);
            kind         = $urandom_range(0, 9);
            if (!did_saturate && requests_sent > 200) begin
                // hammer one resident key past the reference count ceiling
                did_saturate = 1'b1;
                sat_slot     = -1;
                foreach (model.slot_used[i]) begin
                    if (model.slot_used[i]) begin
                        sat_slot = i;
                    end
                end
                if (sat_slot >= 0) begin
                    repeat (260) begin
                        send_request(lookup_req(model.slot_style[sat_slot],
                                                model.slot_size[sat_slot]));
                    end
                    repeat (3) send_request(release_req(5'(sat_slot)));
                end
            end else if (!did_hold && requests_sent > 450) begin
                // receiver holds off while requests keep coming back to back
                did_hold     = 1'b1;
                hold_go      = 1'b1;
                quiet_sender = 1'b1;
                run_mix(30);
                // sender then pauses until every reply is back
                wait_replies_drained();
            end else if (kind == 0) begin
                // fresh keys: fills, then evictions or a full cache
                repeat (ENTRIES + 2) begin
                    send_request(lookup_req(16'($urandom), 8'($urandom)));
                end
            end else if (kind == 1) begin
                // unpin a batch of slots
                repeat (24) send_request(release_req(model.pick_held_slot()));
            end else if (kind == 2) begin
                wait_replies_drained();
            end else begin
                run_mix($urandom_range(10, 40));
            end
        end

        // drain, then allow one more full scan for a stray reply
        wait_replies_drained();
        repeat (ENTRIES + 8) @(posedge aclk);
        if (model.mismatches == 0 && model.expected_replies.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // receiver: random stall before each reply transaction, with calm stretches
    initial begin
        int stall;
        int calm_left;
        calm_left = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (calm_left > 0) begin
                calm_left--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_IDLE);
                if ($urandom_range(0, 39) == 0) begin
                    calm_left = $urandom_range(10, 60);
                end
            end
            if (stall > 0) begin
                rx_want <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            rx_want <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            model.check_reply(m_data);
        end
    end

    // long receiver hold-off, counted here so the block fills and stalls its input
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // watchdog on total cycles
    initial begin
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
